[sv/arp_cache_table_macros.svh]
// Assertion macros shared by the ARP cache table modules.
`ifndef ARP_CACHE_TABLE_MACROS_SVH
`define ARP_CACHE_TABLE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ARPCT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("arp cache table check failed");

// Next-cycle implication, checked outside reset.
`define ARPCT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("arp cache table check failed");

`endif

[sv/arpct_pkg.sv]
// Types and constants shared by the ARP cache table modules.
`timescale 1ns / 1ps

package arpct_pkg;

    localparam int IP_W     = 32;
    localparam int MAC_W    = 48;
    localparam int STATUS_W = 3;
    localparam int INDEX_W  = 8;

    localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISS     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CHECK,
        S_DECIDE,
        S_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic scan_step;
        logic mac_rd;
        logic do_update;
        logic do_insert;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last;
        logic hit;
        logic free;
        logic is_add;
        logic out_busy;
    } t_sts;

endpackage

[sv/arpct_ctrl.sv]
// Controller state machine for the ARP cache table: scan, decide, write, report.
`timescale 1ns / 1ps
`include "arp_cache_table_macros.svh"

module arpct_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  arpct_pkg::t_sts  i_sts,
    output logic             o_in_ready,
    output arpct_pkg::t_cmd  o_cmd
);
    import arpct_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                // last compare lands at the end of this cycle
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (!i_sts.is_add) begin
                    o_cmd.mac_rd = i_sts.hit;
                end else if (i_sts.hit) begin
                    o_cmd.do_update = 1'b1;
                end else if (i_sts.free) begin
                    o_cmd.do_insert = 1'b1;
                end
                n_state = S_FINISH;
            end
            S_FINISH: begin
                // hold until the output register can take the beat
                if (!i_sts.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `ARPCT_ASSERT_NEXT(a_accept_starts_scan, i_in_valid && o_in_ready, r_state == S_SCAN)
    `ARPCT_ASSERT_NEXT(a_scan_ends_in_check, (r_state == S_SCAN) && i_sts.scan_last,
                       r_state == S_CHECK)
    `ARPCT_ASSERT_NEXT(a_decide_to_finish, r_state == S_DECIDE, r_state == S_FINISH)

endmodule

[sv/arpct_dpath.sv]
// Datapath for the ARP cache table: entry storage, scan, match and result register.
`timescale 1ns / 1ps
`include "arp_cache_table_macros.svh"

module arpct_dpath #(
    parameter int ENTRIES = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  arpct_pkg::t_cmd                 i_cmd,
    input  logic                            i_req_type,
    input  logic [arpct_pkg::IP_W-1:0]      i_ip_addr,
    input  logic [arpct_pkg::MAC_W-1:0]     i_mac_addr,
    input  logic                            i_out_ready,
    output arpct_pkg::t_sts                 o_sts,
    output logic                            o_out_valid,
    output logic [arpct_pkg::STATUS_W-1:0]  o_status,
    output logic [arpct_pkg::MAC_W-1:0]     o_mac_found,
    output logic [arpct_pkg::INDEX_W-1:0]   o_entry_index
);
    import arpct_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    // Entry storage
    logic [IP_W-1:0]  r_ip_mem  [ENTRIES];
    logic [MAC_W-1:0] r_mac_mem [ENTRIES];
    logic [ENTRIES-1:0] r_valid;

    // Request
    logic             r_req_type;
    logic [IP_W-1:0]  r_ip;
    logic [MAC_W-1:0] r_mac;

    // Scan
    logic [IDX_W-1:0] r_addr;
    logic             r_rd_vld;
    logic             r_rd_vbit;
    logic [IDX_W-1:0] r_rd_idx;
    logic [IP_W-1:0]  r_rd_ip;
    logic             r_hit;
    logic [IDX_W-1:0] r_hit_idx;
    logic             r_free;
    logic [IDX_W-1:0] r_free_idx;
    logic [MAC_W-1:0] r_mac_q;

    // Result register
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [MAC_W-1:0]    r_out_mac;
    logic [INDEX_W-1:0]  r_out_index;

    logic                w_match;
    logic                w_empty;
    logic                w_wr_mac;
    logic [IDX_W-1:0]    w_wr_idx;
    logic [STATUS_W-1:0] w_status;
    logic [MAC_W-1:0]    w_mac_found;
    logic [INDEX_W-1:0]  w_index;

    assign w_match  = r_rd_vld && r_rd_vbit && (r_rd_ip == r_ip);
    assign w_empty  = r_rd_vld && !r_rd_vbit;
    assign w_wr_mac = i_cmd.do_update || i_cmd.do_insert;
    assign w_wr_idx = i_cmd.do_update ? r_hit_idx : r_free_idx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req_type <= i_req_type;
            r_ip       <= i_ip_addr;
            r_mac      <= i_mac_addr;
        end
    end

    // Memory writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_insert) begin
            r_ip_mem[r_free_idx] <= r_ip;
        end
        if (w_wr_mac) begin
            r_mac_mem[w_wr_idx] <= r_mac;
        end
    end

    // Memory reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step) begin
            r_rd_ip   <= r_ip_mem[r_addr];
            r_rd_idx  <= r_addr;
            r_rd_vbit <= r_valid[r_addr];
        end
        if (i_cmd.mac_rd) begin
            r_mac_q <= r_mac_mem[r_hit_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.do_insert) begin
            r_valid[r_free_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
            r_hit    <= 1'b0;
            r_free   <= 1'b0;
        end else if (i_cmd.capture) begin
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
            r_hit    <= 1'b0;
            r_free   <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan_step;
            if (i_cmd.scan_step && (r_addr != LAST_IDX)) begin
                r_addr <= r_addr + 1'b1;
            end
            // keep the lowest matching and the lowest empty entry
            if (w_match && !r_hit) begin
                r_hit <= 1'b1;
            end
            if (w_empty && !r_free) begin
                r_free <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_match && !r_hit) begin
            r_hit_idx <= r_rd_idx;
        end
        if (w_empty && !r_free) begin
            r_free_idx <= r_rd_idx;
        end
    end

    always_comb begin
        w_mac_found = '0;
        w_index     = '0;
        if (!r_req_type) begin
            if (r_hit) begin
                w_status    = ST_HIT;
                w_mac_found = r_mac_q;
                w_index     = INDEX_W'(r_hit_idx);
            end else begin
                w_status = ST_MISS;
            end
        end else if (r_hit) begin
            w_status = ST_UPDATED;
            w_index  = INDEX_W'(r_hit_idx);
        end else if (r_free) begin
            w_status = ST_INSERTED;
            w_index  = INDEX_W'(r_free_idx);
        end else begin
            w_status = ST_FULL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status <= w_status;
            r_out_mac    <= w_mac_found;
            r_out_index  <= w_index;
        end
    end

    assign o_sts.scan_last = (r_addr == LAST_IDX);
    assign o_sts.hit       = r_hit;
    assign o_sts.free      = r_free;
    assign o_sts.is_add    = r_req_type;
    assign o_sts.out_busy  = r_out_valid && !i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_mac_found   = r_out_mac;
    assign o_entry_index = r_out_index;

    `ARPCT_ASSERT_SAME(a_insert_needs_free_slot, i_cmd.do_insert,
                       r_free && !r_hit && r_req_type)
    `ARPCT_ASSERT_SAME(a_update_needs_hit, i_cmd.do_update, r_hit && r_req_type)
    `ARPCT_ASSERT_NEXT(a_load_shows_result, i_cmd.load_out, r_out_valid)

endmodule

[sv/arp_cache_table.sv]
// A request is captured, then scanned across all ENTRIES entries, checked and decided; the finish step loads
// the result register once it is not busy. The scan reads one IP entry per cycle through the single read port
// of the IP store, and no new request is taken until the controller is back in idle.
// A new request is taken while the previous result still waits in the output register.
// Reset (synchronous, active low) clears all valid bits and the controller; the table starts empty.
`timescale 1ns / 1ps

module arp_cache_table #(
    parameter int ENTRIES = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_req_type,
    input  logic [arpct_pkg::IP_W-1:0]      i_ip_addr,
    input  logic [arpct_pkg::MAC_W-1:0]     i_mac_addr,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [arpct_pkg::STATUS_W-1:0]  o_status,
    output logic [arpct_pkg::MAC_W-1:0]     o_mac_found,
    output logic [arpct_pkg::INDEX_W-1:0]   o_entry_index
);
    import arpct_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    arpct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    arpct_dpath #(
        .ENTRIES (ENTRIES)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_req_type    (i_req_type),
        .i_ip_addr     (i_ip_addr),
        .i_mac_addr    (i_mac_addr),
        .i_out_ready   (i_out_ready),
        .o_sts         (w_sts),
        .o_out_valid   (o_out_valid),
        .o_status      (o_status),
        .o_mac_found   (o_mac_found),
        .o_entry_index (o_entry_index)
    );

endmodule
